FILE: hdl/sdspi_pkg.sv
// Package: types, codes and constants for the SD card SPI host sequencer.
`default_nettype none
package sdspi_pkg;

  localparam int unsigned BlockBytesDef = 512;

  // Operation codes of an input beat
  typedef enum logic [2:0] {
    OP_RX    = 3'd0,
    OP_INIT  = 3'd1,
    OP_READ  = 3'd2,
    OP_WRITE = 3'd3,
    OP_WDATA = 3'd4
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_XFER  = 2'd0,
    KIND_RDATA = 2'd1,
    KIND_WREQ  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  // Done status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CMD0_BAD  = 3'd1,
    ST_CMD1_TO   = 3'd2,
    ST_CMD_REJ   = 3'd3,
    ST_DATA_REJ  = 3'd4,
    ST_BUSY_TO   = 3'd5
  } status_e;

  // Sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE, PH_CLK, PH_CMD0, PH_R10, PH_GAP0, PH_CMD, PH_R1, PH_C1TAIL,
    PH_RGAP, PH_RTOKEN, PH_RDATA, PH_RTAIL, PH_WGAP, PH_WTOK, PH_WNEED,
    PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY
  } phase_e;

  // Operation in progress
  typedef enum logic [1:0] {
    OPR_NONE  = 2'd0,
    OPR_INIT  = 2'd1,
    OPR_READ  = 2'd2,
    OPR_WRITE = 2'd3
  } oper_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_POLL_LIMIT  = 1'b0,
    CFG_INIT_CLOCKS = 1'b1
  } cfg_e;

  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0] Cmd0Byte   = 8'h40;
  localparam logic [7:0] Cmd1Byte   = 8'h41;
  localparam logic [7:0] Cmd17Byte  = 8'h51;
  localparam logic [7:0] Cmd24Byte  = 8'h58;
  localparam logic [7:0] CrcByte    = 8'h95;
  localparam logic [7:0] TokenByte  = 8'hFE;
  localparam logic [7:0] DataRspOk  = 8'h05;
  localparam logic [7:0] IdleByte   = 8'hFF;
  localparam logic [7:0] R1IdleByte = 8'h01;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  rx_byte;
    logic [31:0] block_addr;
    logic [7:0]  wr_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       select_active;
    logic [7:0] rd_byte;
    logic [2:0] status;
    logic       last;
  } out_t;

endpackage
`default_nettype wire

FILE: hdl/sdspi_outq.sv
// Two-entry result queue between the sequencer and the output channel.
`default_nettype none
module sdspi_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [1:0]        push_n_i,
  input  wire sdspi_pkg::out_t   push_a_i,
  input  wire sdspi_pkg::out_t   push_b_i,
  output logic                   empty_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sdspi_pkg::out_t        out_data_o
);

  sdspi_pkg::out_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];
  assign empty_o     = (cnt_q == 2'd0);

  // Count: pushes only happen into an empty queue or one being drained
  always_comb begin
    cnt_d = cnt_q;
    if (pop) cnt_d = cnt_d - 2'd1;
    if (push_i) cnt_d = cnt_d + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Entries: push lands at slot 0 when empty after pop
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[0] <= push_a_i;
      ent_q[1] <= push_b_i;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sd_card_spi_host_sequencer_unit.sv
// SD card SPI host sequencer: top level with byte-level command sequencing.
// Each input beat is handled combinationally: the sequencer state and the beat give
// one or two result beats, loaded into a two-entry output queue, and the first
// of them shows on the output in the cycle after the input beat is accepted. A new
// beat is taken whenever the queue is empty, or holds one beat that leaves this
// cycle, so with a ready consumer one beat per clock passes. A beat in the read
// data phase yields two results (the data byte and the next exchange), so there
// the next input beat waits until the first of the two has left the queue.
`default_nettype none
module sd_card_spi_host_sequencer_unit #(
  parameter int unsigned BlockBytes = sdspi_pkg::BlockBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [sdspi_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sdspi_pkg::in_t                in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sdspi_pkg::out_t                    out_data_o
);

  // Byte counter also counts init clocks, so it never drops below 8 bits
  localparam int unsigned CntW = ($clog2(BlockBytes + 1) > 8) ? $clog2(BlockBytes + 1) : 8;
  localparam logic [CntW-1:0] BlockCnt = CntW'(BlockBytes);

  logic [15:0] poll_limit_q;
  logic [7:0]  init_clocks_q;
  sdspi_pkg::phase_e phase_q, phase_d;
  sdspi_pkg::oper_e  oper_q, oper_d;
  logic [CntW-1:0] bcnt_q, bcnt_d;
  logic [15:0] poll_q, poll_d, retry_q, retry_d;
  logic [2:0]  cidx_q, cidx_d;
  logic [31:0] addr_q, addr_d;
  logic        sel_q, sel_d;
  logic [7:0]  lastr_q, lastr_d;

  logic accept, q_empty, q_last, q_cnt2;
  logic [1:0] n_res;
  sdspi_pkg::out_t res_a, res_b;
  logic [15:0] poll_inc, retry_inc;
  logic [7:0] rx;

  assign q_last     = out_valid_o && out_ready_i && !(q_empty);
  assign in_ready_o = q_empty || (q_last && !(out_valid_o && q_cnt2));
  assign accept = in_valid_i && in_ready_o;
  assign rx = in_data_i.rx_byte;
  assign poll_inc  = poll_q + 16'd1;
  assign retry_inc = retry_q + 16'd1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q  <= 16'hFFFF;
      init_clocks_q <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdspi_pkg::CFG_POLL_LIMIT:  poll_limit_q  <= cfg_data_i;
        sdspi_pkg::CFG_INIT_CLOCKS: init_clocks_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic hit(input logic [15:0] n, input logic [15:0] lim);
    hit = (n >= lim);
  endfunction

  // Command frame byte
  function automatic logic [7:0] cmd_byte(input logic [2:0] idx, input logic is0,
                                          input sdspi_pkg::oper_e opr,
                                          input logic [31:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (idx == 3'd0) begin
      if (is0) b = sdspi_pkg::Cmd0Byte;
      else if (opr == sdspi_pkg::OPR_READ) b = sdspi_pkg::Cmd17Byte;
      else if (opr == sdspi_pkg::OPR_WRITE) b = sdspi_pkg::Cmd24Byte;
      else b = sdspi_pkg::Cmd1Byte;
    end else if (idx >= 3'd5) begin
      b = sdspi_pkg::CrcByte;
    end else if (opr != sdspi_pkg::OPR_INIT) begin
      case (idx)
        3'd1: b = a[31:24];
        3'd2: b = a[23:16];
        3'd3: b = a[15:8];
        default: b = a[7:0];
      endcase
    end
    cmd_byte = b;
  endfunction

  // Next state and result beats
  always_comb begin
    logic [7:0] txa;
    logic [1:0] ka;
    logic [2:0] sta;
    logic       fin;
    phase_d = phase_q; oper_d = oper_q; bcnt_d = bcnt_q; poll_d = poll_q;
    retry_d = retry_q; cidx_d = cidx_q; addr_d = addr_q; sel_d = sel_q;
    lastr_d = lastr_q;
    n_res = 2'd0;
    txa = sdspi_pkg::IdleByte; ka = sdspi_pkg::KIND_XFER; sta = sdspi_pkg::ST_OK;
    fin = 1'b0;
    res_b = '0;
    case (in_data_i.op)
      sdspi_pkg::OP_RX: begin
        if (phase_q != sdspi_pkg::PH_IDLE && phase_q != sdspi_pkg::PH_WNEED) begin
          n_res = 2'd1;
          case (phase_q)
            sdspi_pkg::PH_CLK: begin
              bcnt_d = bcnt_q + 1'b1;
              if (bcnt_d >= CntW'(init_clocks_q)) begin
                sel_d = 1'b1; cidx_d = 3'd0; phase_d = sdspi_pkg::PH_CMD0;
                txa = sdspi_pkg::Cmd0Byte;
              end
            end
            sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD: begin
              cidx_d = cidx_q + 3'd1;
              if (cidx_d < 3'd6) begin
                txa = cmd_byte(cidx_d, phase_q == sdspi_pkg::PH_CMD0, oper_q, addr_q);
              end else begin
                poll_d = 16'd0;
                phase_d = (phase_q == sdspi_pkg::PH_CMD0) ? sdspi_pkg::PH_R10
                                                          : sdspi_pkg::PH_R1;
              end
            end
            sdspi_pkg::PH_R10, sdspi_pkg::PH_R1: begin
              poll_d = poll_inc; lastr_d = rx;
              if (!(rx[7] && !hit(poll_inc, poll_limit_q))) begin
                if (phase_q == sdspi_pkg::PH_R10) begin
                  if (rx == sdspi_pkg::R1IdleByte) phase_d = sdspi_pkg::PH_GAP0;
                  else begin fin = 1'b1; sta = sdspi_pkg::ST_CMD0_BAD; end
                end else if (oper_q == sdspi_pkg::OPR_INIT) begin
                  phase_d = sdspi_pkg::PH_C1TAIL;
                end else if (rx != 8'h00) begin
                  fin = 1'b1; sta = sdspi_pkg::ST_CMD_REJ;
                end else begin
                  phase_d = (oper_q == sdspi_pkg::OPR_READ) ? sdspi_pkg::PH_RGAP
                                                            : sdspi_pkg::PH_WGAP;
                end
              end
            end
            sdspi_pkg::PH_GAP0: begin
              retry_d = 16'd0; cidx_d = 3'd0; phase_d = sdspi_pkg::PH_CMD;
              txa = cmd_byte(3'd0, 1'b0, oper_q, addr_q);
            end
            sdspi_pkg::PH_C1TAIL: begin
              retry_d = retry_inc;
              if (lastr_q == 8'h00) begin fin = 1'b1; sta = sdspi_pkg::ST_OK; end
              else if (hit(retry_inc, poll_limit_q)) begin
                fin = 1'b1; sta = sdspi_pkg::ST_CMD1_TO;
              end else begin
                cidx_d = 3'd0; phase_d = sdspi_pkg::PH_CMD;
                txa = cmd_byte(3'd0, 1'b0, oper_q, addr_q);
              end
            end
            sdspi_pkg::PH_RGAP: begin
              poll_d = 16'd0; phase_d = sdspi_pkg::PH_RTOKEN;
            end
            sdspi_pkg::PH_RTOKEN: begin
              poll_d = poll_inc;
              if (rx == sdspi_pkg::TokenByte || hit(poll_inc, poll_limit_q)) begin
                bcnt_d = '0; phase_d = sdspi_pkg::PH_RDATA;
              end
            end
            sdspi_pkg::PH_RDATA: begin
              // data byte first, then the next exchange
              n_res = 2'd2;
              bcnt_d = bcnt_q + 1'b1;
              if (bcnt_d >= BlockCnt) begin
                bcnt_d = '0; phase_d = sdspi_pkg::PH_RTAIL;
              end
            end
            sdspi_pkg::PH_RTAIL: begin
              bcnt_d = bcnt_q + 1'b1;
              if (bcnt_d >= CntW'(3)) begin fin = 1'b1; sta = sdspi_pkg::ST_OK; end
            end
            sdspi_pkg::PH_WGAP: begin
              phase_d = sdspi_pkg::PH_WTOK; txa = sdspi_pkg::TokenByte;
            end
            sdspi_pkg::PH_WTOK: begin
              bcnt_d = '0; phase_d = sdspi_pkg::PH_WNEED; ka = sdspi_pkg::KIND_WREQ;
            end
            sdspi_pkg::PH_WDATA: begin
              bcnt_d = bcnt_q + 1'b1;
              if (bcnt_d < BlockCnt) begin
                phase_d = sdspi_pkg::PH_WNEED; ka = sdspi_pkg::KIND_WREQ;
              end else begin
                bcnt_d = '0; phase_d = sdspi_pkg::PH_WCRC;
              end
            end
            sdspi_pkg::PH_WCRC: begin
              bcnt_d = bcnt_q + 1'b1;
              if (bcnt_d < CntW'(2)) txa = sdspi_pkg::TokenByte;
              else phase_d = sdspi_pkg::PH_WRESP;
            end
            sdspi_pkg::PH_WRESP: begin
              lastr_d = rx;
              if ((rx & sdspi_pkg::DataRspOk) != sdspi_pkg::DataRspOk) begin
                fin = 1'b1; sta = sdspi_pkg::ST_DATA_REJ;
              end else begin
                poll_d = 16'd0; phase_d = sdspi_pkg::PH_WBUSY;
              end
            end
            sdspi_pkg::PH_WBUSY: begin
              poll_d = poll_inc; lastr_d = rx;
              if (rx == 8'hFF) begin fin = 1'b1; sta = sdspi_pkg::ST_OK; end
              else if (hit(poll_inc, poll_limit_q)) begin
                fin = 1'b1; sta = sdspi_pkg::ST_BUSY_TO;
              end
            end
            default: n_res = 2'd0;
          endcase
        end
      end
      sdspi_pkg::OP_INIT, sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
        if (phase_q == sdspi_pkg::PH_IDLE) begin
          n_res = 2'd1;
          oper_d = sdspi_pkg::oper_e'(in_data_i.op[1:0]);
          cidx_d = 3'd0;
          if (in_data_i.op == sdspi_pkg::OP_INIT) begin
            bcnt_d = '0;
            if (init_clocks_q == 8'd0) begin
              sel_d = 1'b1; phase_d = sdspi_pkg::PH_CMD0; txa = sdspi_pkg::Cmd0Byte;
            end else begin
              sel_d = 1'b0; phase_d = sdspi_pkg::PH_CLK;
            end
          end else begin
            addr_d = in_data_i.block_addr; sel_d = 1'b1; phase_d = sdspi_pkg::PH_CMD;
            txa = (in_data_i.op == sdspi_pkg::OP_READ) ? sdspi_pkg::Cmd17Byte
                                                       : sdspi_pkg::Cmd24Byte;
          end
        end
      end
      sdspi_pkg::OP_WDATA: begin
        if (phase_q == sdspi_pkg::PH_WNEED) begin
          n_res = 2'd1; phase_d = sdspi_pkg::PH_WDATA; txa = in_data_i.wr_byte;
        end
      end
      default: n_res = 2'd0;
    endcase
    if (fin) begin
      phase_d = sdspi_pkg::PH_IDLE; oper_d = sdspi_pkg::OPR_NONE;
      ka = sdspi_pkg::KIND_DONE; txa = sdspi_pkg::IdleByte;
    end
    if (ka != sdspi_pkg::KIND_XFER) txa = sdspi_pkg::IdleByte;
    // Exchange, write request or done beat
    res_a.kind = ka;
    res_a.tx_byte = txa;
    res_a.select_active = sel_d;
    res_a.rd_byte = 8'h00;
    res_a.status = fin ? sta : sdspi_pkg::ST_OK;
    res_a.last = 1'b1;
    res_b = res_a;
    if (n_res == 2'd2) begin
      // read data byte goes out ahead of the next exchange
      res_a.kind = sdspi_pkg::KIND_RDATA;
      res_a.tx_byte = sdspi_pkg::IdleByte;
      res_a.rd_byte = rx;
      res_a.status = sdspi_pkg::ST_OK;
      res_a.last = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdspi_pkg::PH_IDLE; oper_q <= sdspi_pkg::OPR_NONE;
      bcnt_q <= '0; poll_q <= '0; retry_q <= '0; cidx_q <= '0;
      addr_q <= '0; sel_q <= 1'b0; lastr_q <= 8'hFF;
    end else if (accept) begin
      phase_q <= phase_d; oper_q <= oper_d; bcnt_q <= bcnt_d; poll_q <= poll_d;
      retry_q <= retry_d; cidx_q <= cidx_d; addr_q <= addr_d; sel_q <= sel_d;
      lastr_q <= lastr_d;
    end
  end

  // Queue holds at most two beats; the second beat exists only right after a push of two
  logic [1:0] qn_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qn_q <= 2'd0;
    end else begin
      qn_q <= qn_q - {1'b0, out_valid_o && out_ready_i}
                   + ((accept && n_res != 2'd0) ? n_res : 2'd0);
    end
  end
  assign q_cnt2 = (qn_q == 2'd2);

  sdspi_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && n_res != 2'd0),
    .push_n_i    (n_res),
    .push_a_i    (res_a),
    .push_b_i    (res_b),
    .empty_o     (q_empty),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: hdl/sdspi_checker.sv
// Port-level checker for the SD card SPI host sequencer, bound to the top level.
`default_nettype none
module sdspi_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire sdspi_pkg::out_t out_data_o
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Input is only held off while results are waiting
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o)
    else $error("input held off with no result pending");

  // Only exchange beats carry a byte other than 0xFF
  a_tx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != sdspi_pkg::KIND_XFER |->
      out_data_o.tx_byte == sdspi_pkg::IdleByte)
    else $error("non-exchange beat with tx byte");

  // Read data beat is never the final beat of an input
  a_rd_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == sdspi_pkg::KIND_RDATA |-> !out_data_o.last)
    else $error("read data beat marked last");

  // Status only on done beats
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != sdspi_pkg::KIND_DONE |->
      out_data_o.status == sdspi_pkg::ST_OK)
    else $error("status on non-done beat");

endmodule

bind sd_card_spi_host_sequencer_unit sdspi_checker u_sdspi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

FILE: test/sd_card_spi_host_sequencer_unit_tb.sv
// Testbench for the SD card SPI host sequencer: card-emulating stimulus, predictor, checker.
`default_nettype none
module sd_card_spi_host_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBlk     = sdspi_pkg::BlockBytesDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PlanItems  = 1600;

  // DUT ports
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic                           cfg_idx_i = 1'b0;
  logic [sdspi_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  sdspi_pkg::in_t                 in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  sdspi_pkg::out_t                out_data_o;

  sd_card_spi_host_sequencer_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  // Run bookkeeping
  int unsigned cycles = 0;
  int unsigned fails = 0;
  int unsigned work_beats = 0;
  int unsigned noise_beats = 0;
  int unsigned res_beats = 0;
  int unsigned n_reads = 0, n_writes = 0, n_inits = 0;
  bit          quiet = 1'b0;
  int          card_mode = 0;  // 0 healthy card, 1 faulty answers, 2 never answers

  sdspi_pkg::out_t exp_beats[$];

  // Predictor state
  sdspi_pkg::phase_e ph;
  sdspi_pkg::oper_e  oper;
  int unsigned bcnt;
  logic [15:0] pcnt;
  logic [15:0] retries;
  int unsigned cidx;
  logic [31:0] addr;
  logic        sel;
  logic [7:0]  last_rsp;
  logic [15:0] plim;
  logic [7:0]  iclk;

  task automatic push(input sdspi_pkg::kind_e k, input logic [7:0] tx,
                      input logic [7:0] rd, input sdspi_pkg::status_e st);
    sdspi_pkg::out_t o;
    o.kind = k; o.tx_byte = tx; o.select_active = sel;
    o.rd_byte = rd; o.status = st; o.last = 1'b0;
    exp_beats.push_back(o);
  endtask

  task automatic xfer(input sdspi_pkg::phase_e nxt, input logic [7:0] tx);
    ph = nxt;
    push(sdspi_pkg::KIND_XFER, tx, 8'h00, sdspi_pkg::ST_OK);
  endtask

  task automatic done(input sdspi_pkg::status_e st);
    ph = sdspi_pkg::PH_IDLE;
    oper = sdspi_pkg::OPR_NONE;
    push(sdspi_pkg::KIND_DONE, sdspi_pkg::IdleByte, 8'h00, st);
  endtask

  function automatic logic [7:0] frame_byte(input int unsigned i, input bit is_cmd0);
    if (i == 0) begin
      if (is_cmd0) return sdspi_pkg::Cmd0Byte;
      if (oper == sdspi_pkg::OPR_READ) return sdspi_pkg::Cmd17Byte;
      if (oper == sdspi_pkg::OPR_WRITE) return sdspi_pkg::Cmd24Byte;
      return sdspi_pkg::Cmd1Byte;
    end
    if (i >= 5) return sdspi_pkg::CrcByte;
    if (oper == sdspi_pkg::OPR_INIT) return 8'h00;
    return addr[(4 - i) * 8 +: 8];
  endfunction

  task automatic start_frame(input bit is_cmd0);
    cidx = 0;
    xfer(is_cmd0 ? sdspi_pkg::PH_CMD0 : sdspi_pkg::PH_CMD, frame_byte(0, is_cmd0));
  endtask

  // Card byte returned for the outstanding exchange
  task automatic take_card_byte(input logic [7:0] rx);
    case (ph)
      sdspi_pkg::PH_CLK: begin
        bcnt++;
        if (bcnt >= iclk) begin
          sel = 1'b1; start_frame(1'b1);
        end else xfer(sdspi_pkg::PH_CLK, sdspi_pkg::IdleByte);
      end
      sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD: begin
        cidx++;
        if (cidx < 6) xfer(ph, frame_byte(cidx, ph == sdspi_pkg::PH_CMD0));
        else begin
          pcnt = '0;
          xfer(ph == sdspi_pkg::PH_CMD0 ? sdspi_pkg::PH_R10 : sdspi_pkg::PH_R1,
               sdspi_pkg::IdleByte);
        end
      end
      sdspi_pkg::PH_R10, sdspi_pkg::PH_R1: begin
        pcnt++;
        last_rsp = rx;
        if (rx[7] && !(pcnt >= plim)) xfer(ph, sdspi_pkg::IdleByte);
        else if (ph == sdspi_pkg::PH_R10) begin
          if (rx == sdspi_pkg::R1IdleByte) xfer(sdspi_pkg::PH_GAP0, sdspi_pkg::IdleByte);
          else done(sdspi_pkg::ST_CMD0_BAD);
        end else if (oper == sdspi_pkg::OPR_INIT) begin
          xfer(sdspi_pkg::PH_C1TAIL, sdspi_pkg::IdleByte);
        end else if (rx != 8'h00) done(sdspi_pkg::ST_CMD_REJ);
        else xfer(oper == sdspi_pkg::OPR_READ ? sdspi_pkg::PH_RGAP : sdspi_pkg::PH_WGAP,
                  sdspi_pkg::IdleByte);
      end
      sdspi_pkg::PH_GAP0: begin
        retries = '0; start_frame(1'b0);
      end
      sdspi_pkg::PH_C1TAIL: begin
        retries++;
        if (last_rsp == 8'h00) done(sdspi_pkg::ST_OK);
        else if (retries >= plim) done(sdspi_pkg::ST_CMD1_TO);
        else start_frame(1'b0);
      end
      sdspi_pkg::PH_RGAP: begin
        pcnt = '0; xfer(sdspi_pkg::PH_RTOKEN, sdspi_pkg::IdleByte);
      end
      sdspi_pkg::PH_RTOKEN: begin
        pcnt++;
        if (rx == sdspi_pkg::TokenByte || pcnt >= plim) begin
          bcnt = 0; xfer(sdspi_pkg::PH_RDATA, sdspi_pkg::IdleByte);
        end else xfer(sdspi_pkg::PH_RTOKEN, sdspi_pkg::IdleByte);
      end
      sdspi_pkg::PH_RDATA: begin
        push(sdspi_pkg::KIND_RDATA, sdspi_pkg::IdleByte, rx, sdspi_pkg::ST_OK);
        bcnt++;
        if (bcnt < NumBlk) xfer(sdspi_pkg::PH_RDATA, sdspi_pkg::IdleByte);
        else begin
          bcnt = 0; xfer(sdspi_pkg::PH_RTAIL, sdspi_pkg::IdleByte);
        end
      end
      sdspi_pkg::PH_RTAIL: begin
        bcnt++;
        if (bcnt < 3) xfer(sdspi_pkg::PH_RTAIL, sdspi_pkg::IdleByte);
        else done(sdspi_pkg::ST_OK);
      end
      sdspi_pkg::PH_WGAP: xfer(sdspi_pkg::PH_WTOK, sdspi_pkg::TokenByte);
      sdspi_pkg::PH_WTOK: begin
        bcnt = 0; ph = sdspi_pkg::PH_WNEED;
        push(sdspi_pkg::KIND_WREQ, sdspi_pkg::IdleByte, 8'h00, sdspi_pkg::ST_OK);
      end
      sdspi_pkg::PH_WDATA: begin
        bcnt++;
        if (bcnt < NumBlk) begin
          ph = sdspi_pkg::PH_WNEED;
          push(sdspi_pkg::KIND_WREQ, sdspi_pkg::IdleByte, 8'h00, sdspi_pkg::ST_OK);
        end else begin
          bcnt = 0; xfer(sdspi_pkg::PH_WCRC, sdspi_pkg::IdleByte);
        end
      end
      sdspi_pkg::PH_WCRC: begin
        bcnt++;
        if (bcnt < 2) xfer(sdspi_pkg::PH_WCRC, sdspi_pkg::TokenByte);
        else xfer(sdspi_pkg::PH_WRESP, sdspi_pkg::IdleByte);
      end
      sdspi_pkg::PH_WRESP: begin
        last_rsp = rx;
        if ((rx & sdspi_pkg::DataRspOk) != sdspi_pkg::DataRspOk) done(sdspi_pkg::ST_DATA_REJ);
        else begin
          pcnt = '0; xfer(sdspi_pkg::PH_WBUSY, sdspi_pkg::IdleByte);
        end
      end
      sdspi_pkg::PH_WBUSY: begin
        pcnt++;
        last_rsp = rx;
        if (rx == sdspi_pkg::IdleByte) done(sdspi_pkg::ST_OK);
        else if (pcnt >= plim) done(sdspi_pkg::ST_BUSY_TO);
        else xfer(sdspi_pkg::PH_WBUSY, sdspi_pkg::IdleByte);
      end
      default: ;
    endcase
  endtask

  // Expected results of one accepted input beat
  task automatic seq_step(input sdspi_pkg::in_t b);
    int n0;
    n0 = exp_beats.size();
    case (b.op)
      sdspi_pkg::OP_RX: begin
        if (ph != sdspi_pkg::PH_IDLE && ph != sdspi_pkg::PH_WNEED) take_card_byte(b.rx_byte);
      end
      sdspi_pkg::OP_INIT, sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
        if (ph == sdspi_pkg::PH_IDLE) begin
          oper = sdspi_pkg::oper_e'(b.op[1:0]);
          if (b.op == sdspi_pkg::OP_INIT) begin
            sel = 1'b0; bcnt = 0;
            if (iclk == 0) begin
              sel = 1'b1; start_frame(1'b1);
            end else xfer(sdspi_pkg::PH_CLK, sdspi_pkg::IdleByte);
          end else begin
            addr = b.block_addr; sel = 1'b1; start_frame(1'b0);
          end
        end
      end
      sdspi_pkg::OP_WDATA: begin
        if (ph == sdspi_pkg::PH_WNEED) xfer(sdspi_pkg::PH_WDATA, b.wr_byte);
      end
      default: ;
    endcase
    if (exp_beats.size() > n0) exp_beats[exp_beats.size() - 1].last = 1'b1;
  endtask

  function automatic bit is_ignored(input sdspi_pkg::in_t b);
    case (b.op)
      sdspi_pkg::OP_RX: return ph == sdspi_pkg::PH_IDLE || ph == sdspi_pkg::PH_WNEED;
      sdspi_pkg::OP_INIT, sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE:
        return ph != sdspi_pkg::PH_IDLE;
      sdspi_pkg::OP_WDATA: return ph != sdspi_pkg::PH_WNEED;
      default: return 1'b1;
    endcase
  endfunction

  // Stop driving the input channel before any wait
  task automatic idle_in();
    in_valid_i <= 1'b0;
  endtask

  // Send one beat; valid is left high so a following beat goes out back to back
  task automatic send_beat(input sdspi_pkg::in_t b);
    if (work_beats + noise_beats >= (PlanItems * 4) / 5) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      idle_in();
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    seq_step(b);
  endtask

  // Drain all results, then allow the pipeline to settle
  task automatic drain();
    idle_in();
    while (exp_beats.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic cfg_write(input sdspi_pkg::cfg_e idx, input logic [15:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == sdspi_pkg::CFG_POLL_LIMIT) plim = val;
    else iclk = val[7:0];
  endtask

  // Card answer for the current exchange, shaped by the card mode
  function automatic logic [7:0] card_byte();
    logic [7:0] r;
    int unsigned d;
    r = 8'($urandom_range(0, 255));
    d = $urandom_range(0, 7);
    case (ph)
      sdspi_pkg::PH_R10: begin
        if (card_mode == 2 || d < 2) return r | 8'h80;
        if (card_mode == 1 && d == 2) return 8'($urandom_range(2, 127));
        return sdspi_pkg::R1IdleByte;
      end
      sdspi_pkg::PH_R1: begin
        if (card_mode == 2 || d < 2) return r | 8'h80;
        if (oper == sdspi_pkg::OPR_INIT) return (d < 5) ? 8'h00 : sdspi_pkg::R1IdleByte;
        if (card_mode == 1 && d == 2) return 8'($urandom_range(1, 127));
        return 8'h00;
      end
      sdspi_pkg::PH_RTOKEN: begin
        if (card_mode == 2) return (r == sdspi_pkg::TokenByte) ? 8'h00 : r;
        return (d < 3) ? r : sdspi_pkg::TokenByte;
      end
      sdspi_pkg::PH_WRESP: begin
        if (card_mode == 1 && d < 3) return r & ((d == 0) ? 8'hFE : 8'hFB);
        return r | sdspi_pkg::DataRspOk;
      end
      sdspi_pkg::PH_WBUSY: begin
        if (card_mode == 2 || d >= 3) return r & 8'hFE;
        return sdspi_pkg::IdleByte;
      end
      default: return r;
    endcase
  endfunction

  // One complete operation, answering every exchange; noise_pct mixes in ignored beats
  task automatic run_op(input sdspi_pkg::op_e op, input logic [31:0] a,
                        input int unsigned noise_pct);
    sdspi_pkg::in_t b;
    int unsigned k;
    b = '0;
    b.op = op; b.block_addr = a; b.rx_byte = 8'($urandom_range(0, 255));
    b.wr_byte = 8'($urandom_range(0, 255));
    send_beat(b);
    work_beats++;
    case (op)
      sdspi_pkg::OP_INIT: n_inits++;
      sdspi_pkg::OP_READ: n_reads++;
      default:            n_writes++;
    endcase
    while (ph != sdspi_pkg::PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        for (k = 0; k < 4; k++) begin
          b.op = 3'($urandom_range(0, 7));
          b.rx_byte = 8'($urandom_range(0, 255));
          b.block_addr = $urandom;
          b.wr_byte = 8'($urandom_range(0, 255));
          if (is_ignored(b)) begin
            send_beat(b);
            noise_beats++;
            break;
          end
        end
      end
      b = '0;
      b.block_addr = $urandom;
      if (ph == sdspi_pkg::PH_WNEED) begin
        b.op = sdspi_pkg::OP_WDATA; b.wr_byte = 8'($urandom_range(0, 255));
      end else begin
        b.op = sdspi_pkg::OP_RX; b.rx_byte = card_byte();
      end
      send_beat(b);
      work_beats++;
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_init();
    card_mode = 0;
    run_op(sdspi_pkg::OP_INIT, 32'h0, 0);
  endtask

  task automatic test_init_clocks();
    cfg_write(sdspi_pkg::CFG_INIT_CLOCKS, 16'd0);
    run_op(sdspi_pkg::OP_INIT, 32'hFFFF_FFFF, 0);
    cfg_write(sdspi_pkg::CFG_INIT_CLOCKS, 16'd24);
    run_op(sdspi_pkg::OP_INIT, 32'h0, 0);
    cfg_write(sdspi_pkg::CFG_INIT_CLOCKS, 16'd10);
  endtask

  // Faulty and silent cards against tight poll limits
  task automatic test_errors();
    cfg_write(sdspi_pkg::CFG_POLL_LIMIT, 16'd1);
    card_mode = 2;
    run_op(sdspi_pkg::OP_INIT, 32'h0, 0);     // CMD0 gets no idle answer
    run_op(sdspi_pkg::OP_READ, 32'h1234_5678, 0);
    run_op(sdspi_pkg::OP_WRITE, 32'h8765_4321, 0);
    cfg_write(sdspi_pkg::CFG_POLL_LIMIT, 16'd0);
    run_op(sdspi_pkg::OP_READ, 32'h0000_00FF, 0);
    cfg_write(sdspi_pkg::CFG_POLL_LIMIT, 16'd3);
    card_mode = 1;
    repeat (2) run_op(sdspi_pkg::OP_INIT, $urandom, 0);
    card_mode = 0;
    cfg_write(sdspi_pkg::CFG_POLL_LIMIT, 16'd65535);
  endtask

  // Stray card bytes, data bytes and unknown codes while idle, then noise during init
  task automatic test_ignored();
    sdspi_pkg::in_t b;
    int i;
    for (i = 0; i < 8; i++) begin
      b = '0;
      if (i < 3) b.op = sdspi_pkg::OP_RX;
      else if (i < 5) b.op = sdspi_pkg::OP_WDATA;
      else b.op = 3'(i);
      b.rx_byte = 8'($urandom_range(0, 255));
      b.wr_byte = 8'($urandom_range(0, 255));
      b.block_addr = $urandom;
      send_beat(b);
      noise_beats++;
    end
    run_op(sdspi_pkg::OP_INIT, $urandom, 30);
  endtask

  // Full block read and full block write with stray beats mixed in
  task automatic test_read_write();
    card_mode = 0;
    run_op(sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 3);
    run_op(sdspi_pkg::OP_WRITE, 32'hA5C3_0F81, 3);
  endtask

  // Result checker
  task automatic cmp_field(input string f, input int unsigned e, input int unsigned g);
    if (e != g) begin
      fails++;
      $display("%0t: mismatch %s expected %0h actual %0h", $realtime, f, e, g);
    end
  endtask

  always @(posedge clk_i) begin
    sdspi_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_beats++;
      if (exp_beats.size() == 0) begin
        fails++;
        $display("%0t: unexpected result expected none actual %h", $realtime, out_data_o);
      end else begin
        e = exp_beats.pop_front();
        cmp_field("kind", e.kind, out_data_o.kind);
        cmp_field("tx_byte", e.tx_byte, out_data_o.tx_byte);
        cmp_field("select_active", e.select_active, out_data_o.select_active);
        cmp_field("rd_byte", e.rd_byte, out_data_o.rd_byte);
        cmp_field("status", e.status, out_data_o.status);
        cmp_field("last", e.last, out_data_o.last);
      end
    end
  end

  // Output stalls in random bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, exp_beats.size());
      $display("FAIL sd_card_spi_host_sequencer_unit");
      $finish;
    end
  end

  initial begin
    ph = sdspi_pkg::PH_IDLE; oper = sdspi_pkg::OPR_NONE; bcnt = 0; pcnt = '0;
    retries = '0; cidx = 0; addr = '0; sel = 1'b0; last_rsp = sdspi_pkg::IdleByte;
    plim = 16'hFFFF; iclk = 8'd10;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_init();
    test_init_clocks();
    test_errors();
    test_ignored();
    test_read_write();
    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d inits, %0d reads, %0d writes; %0d card/data beats, %0d ignored beats",
             n_inits, n_reads, n_writes, work_beats, noise_beats);
    $display("%0d result beats checked, %0d mismatches", res_beats, fails);
    if (fails == 0 && exp_beats.size() == 0) begin
      $display("PASS sd_card_spi_host_sequencer_unit");
    end else begin
      $display("FAIL sd_card_spi_host_sequencer_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
